// ===== hdl/hpd_pkg.sv =====
// Shared types and constants for the Huffman prefix decoder.
// Used by every module of the block; depends on nothing.
package hpd_pkg;

  localparam int TABLE_DEPTH_DEF  = 256;
  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int SYMBOL_WIDTH_DEF = 16;

  localparam int INDEX_W     = 8;
  localparam int CODE_W      = 32;
  localparam int LEN_W       = 6;
  localparam int SYM_FIELD_W = 16;

  localparam int IN_TDATA_W  = 64;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = 2;

  typedef enum logic [1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_DECODE = 2'd1,
    FUNC_CLEAR  = 2'd2
  } func_t;

  typedef struct packed {
    logic                   valid;
    func_t                  func;
    logic [INDEX_W-1:0]     index;
    logic [CODE_W-1:0]      code;
    logic [LEN_W-1:0]       length;
    logic [SYM_FIELD_W-1:0] symbol;
  } item_t;

  typedef struct packed {
    logic [SYM_FIELD_W-1:0] symbol;
    logic                   symbol_valid;
    logic                   code_error;
  } result_t;

endpackage

// ===== hdl/hpd_cell.sv =====
// One stage of the decoder chain: holds one table entry and compares it with passing items.
// Depends on hpd_pkg.
module hpd_cell #(
  parameter int MAX_CODE_LEN = hpd_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOL_WIDTH = hpd_pkg::SYMBOL_WIDTH_DEF,
  parameter int CELL_IDX     = 0
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      en,
  input  hpd_pkg::item_t                            item_i,
  input  logic [MAX_CODE_LEN-1:0]                   win_i,
  input  logic [MAX_CODE_LEN-1:0]                   hit_i,
  input  logic [MAX_CODE_LEN-1:0][SYMBOL_WIDTH-1:0] sym_i,
  output hpd_pkg::item_t                            item_o,
  output logic [MAX_CODE_LEN-1:0]                   win_o,
  output logic [MAX_CODE_LEN-1:0]                   hit_o,
  output logic [MAX_CODE_LEN-1:0][SYMBOL_WIDTH-1:0] sym_o
);

  localparam int CMP_W = (MAX_CODE_LEN > hpd_pkg::CODE_W) ? MAX_CODE_LEN : hpd_pkg::CODE_W;

  logic [hpd_pkg::LEN_W-1:0]                 len_r;
  logic [hpd_pkg::CODE_W-1:0]                code_r;
  logic [SYMBOL_WIDTH-1:0]                   sym_r;
  logic                                      valid_r;
  hpd_pkg::item_t                            pay_r;
  logic [MAX_CODE_LEN-1:0]                   win_r;
  logic [MAX_CODE_LEN-1:0]                   hit_r;
  logic [MAX_CODE_LEN-1:0][SYMBOL_WIDTH-1:0] syms_r;

  logic                                      wr_sel;
  logic [hpd_pkg::CODE_W-1:0]                code_nxt;
  logic [CMP_W-1:0]                          len_mask;
  logic                                      match;
  logic [MAX_CODE_LEN-1:0]                   take_vec;
  logic [MAX_CODE_LEN-1:0]                   hit_nxt;
  logic [MAX_CODE_LEN-1:0][SYMBOL_WIDTH-1:0] syms_nxt;

  always_comb begin
    wr_sel = item_i.valid && (item_i.func == hpd_pkg::FUNC_WRITE) &&
             (int'(item_i.index) == CELL_IDX);
    for (int b = 0; b < hpd_pkg::CODE_W; b++) begin
      code_nxt[b] = item_i.code[b] & (b < int'(item_i.length));
    end
    for (int b = 0; b < CMP_W; b++) begin
      len_mask[b] = (b < int'(len_r));
    end
    match = item_i.valid && (item_i.func == hpd_pkg::FUNC_DECODE) && (len_r != '0) &&
            (int'(len_r) <= MAX_CODE_LEN) &&
            ((CMP_W'(win_i) & len_mask) == CMP_W'(code_r));
    for (int l = 0; l < MAX_CODE_LEN; l++) begin
      take_vec[l] = match && (int'(len_r) == l + 1) && !hit_i[l];
      hit_nxt[l]  = hit_i[l] | take_vec[l];
      syms_nxt[l] = take_vec[l] ? sym_r : sym_i[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (en && wr_sel) begin
        len_r <= item_i.length;
      end
      if (en) begin
        valid_r <= item_i.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && wr_sel) begin
      code_r <= code_nxt;
      sym_r  <= SYMBOL_WIDTH'(item_i.symbol);
    end
    if (en) begin
      pay_r  <= item_i;
      win_r  <= win_i;
      hit_r  <= hit_nxt;
      syms_r <= syms_nxt;
    end
  end

  always_comb begin
    item_o       = pay_r;
    item_o.valid = valid_r;
  end

  assign win_o = win_r;
  assign hit_o = hit_r;
  assign sym_o = syms_r;

endmodule

// ===== hdl/hpd_tail.sv =====
// End of the decoder chain: tracks the gathered bit count, forms results and buffers them.
// Depends on hpd_pkg.
module hpd_tail #(
  parameter int MAX_CODE_LEN = hpd_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOL_WIDTH = hpd_pkg::SYMBOL_WIDTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  hpd_pkg::item_t                            item_i,
  input  logic [MAX_CODE_LEN-1:0]                   hit_i,
  input  logic [MAX_CODE_LEN-1:0][SYMBOL_WIDTH-1:0] sym_i,
  output logic                                      ready_o,
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  output logic [hpd_pkg::OUT_TDATA_W-1:0]           out_tdata,
  output logic [hpd_pkg::OUT_TUSER_W-1:0]           out_tuser
);

  localparam int CNT_W = $clog2(MAX_CODE_LEN);
  localparam int SYM_W = hpd_pkg::SYM_FIELD_W;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic             skid_valid_r;
  hpd_pkg::result_t out_r;
  hpd_pkg::result_t skid_r;
  hpd_pkg::result_t res;
  logic             res_valid;
  logic             take;
  logic             hit;
  logic             at_limit;

  assign ready_o  = !skid_valid_r;
  assign take     = item_i.valid && ready_o;
  assign hit      = hit_i[count_r];
  assign at_limit = (count_r == CNT_W'(MAX_CODE_LEN - 1));

  always_comb begin
    count_nxt        = count_r;
    res_valid        = 1'b0;
    res.symbol       = hit ? SYM_W'(sym_i[count_r]) : '0;
    res.symbol_valid = hit;
    res.code_error   = !hit;
    if (take) begin
      unique case (item_i.func)
        hpd_pkg::FUNC_DECODE: begin
          res_valid = hit || at_limit;
          count_nxt = (hit || at_limit) ? '0 : count_r + CNT_W'(1);
        end
        hpd_pkg::FUNC_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (!out_valid_r || out_tready) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= res_valid;
        end
      end else if (res_valid) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (res_valid) begin
        out_r <= res;
      end
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.symbol;
  assign out_tuser  = {out_r.code_error, out_r.symbol_valid};

endmodule

// ===== hdl/huffman_prefix_decoder.sv =====
// Top level of the Huffman prefix decoder: input head, row of table cells, result tail.
// Depends on hpd_pkg, hpd_cell and hpd_tail.
//
// The decoder takes one item per clock while in_tready is high: a table write, one
// stream bit to decode, or a clear of the gathered bits. Every item walks a row of
// TABLE_DEPTH cells, one cell per clock while in_tready is high, and each cell holds
// one table entry. Each decode item carries the last MAX_CODE_LEN stream bits and
// collects, per code length, whether an entry matched and the symbol of the lowest
// matching entry, so the tail only has to pick the length given by its bit count.
// A write reaches its cell before any later item does, so writes and decodes may be
// mixed freely. The table is empty after reset with no clearing pass. in_tready
// falls only while a result waits behind a stalled output.
module huffman_prefix_decoder #(
  parameter int TABLE_DEPTH  = hpd_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_CODE_LEN = hpd_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOL_WIDTH = hpd_pkg::SYMBOL_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // entry_index[7:0], entry_code[39:8], entry_length[45:40], entry_symbol[61:46],
  // bit_in[62], zero[63]
  input  logic [hpd_pkg::IN_TDATA_W-1:0]  in_tdata,
  // func[1:0]
  input  logic [hpd_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // symbol[15:0]
  output logic [hpd_pkg::OUT_TDATA_W-1:0] out_tdata,
  // symbol_valid[0], code_error[1]
  output logic [hpd_pkg::OUT_TUSER_W-1:0] out_tuser
);

  logic                                      en;
  logic                                      accepted;
  logic                                      bit_in;
  logic [MAX_CODE_LEN-1:0]                   hist_r;
  logic [MAX_CODE_LEN-1:0]                   hist_nxt;
  hpd_pkg::item_t                            head_item;

  hpd_pkg::item_t                            item_chain [TABLE_DEPTH+1];
  logic [MAX_CODE_LEN-1:0]                   win_chain  [TABLE_DEPTH+1];
  logic [MAX_CODE_LEN-1:0]                   hit_chain  [TABLE_DEPTH+1];
  logic [MAX_CODE_LEN-1:0][SYMBOL_WIDTH-1:0] sym_chain  [TABLE_DEPTH+1];

  assign in_tready = en;
  assign accepted  = in_tvalid && en;
  assign bit_in    = in_tdata[62];
  assign hist_nxt  = {hist_r[MAX_CODE_LEN-2:0], bit_in};

  always_comb begin
    head_item.valid  = accepted;
    head_item.func   = hpd_pkg::func_t'(in_tuser);
    head_item.index  = in_tdata[7:0];
    head_item.code   = in_tdata[39:8];
    head_item.length = in_tdata[45:40];
    head_item.symbol = in_tdata[61:46];
  end

  always_ff @(posedge clk) begin
    if (accepted && (head_item.func == hpd_pkg::FUNC_DECODE)) begin
      hist_r <= hist_nxt;
    end
  end

  assign item_chain[0] = head_item;
  assign win_chain[0]  = hist_nxt;
  assign hit_chain[0]  = '0;
  assign sym_chain[0]  = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_stage
    hpd_cell #(
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .SYMBOL_WIDTH (SYMBOL_WIDTH),
      .CELL_IDX     (i)
    ) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .item_i (item_chain[i]),
      .win_i  (win_chain[i]),
      .hit_i  (hit_chain[i]),
      .sym_i  (sym_chain[i]),
      .item_o (item_chain[i+1]),
      .win_o  (win_chain[i+1]),
      .hit_o  (hit_chain[i+1]),
      .sym_o  (sym_chain[i+1])
    );
  end

  hpd_tail #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_WIDTH (SYMBOL_WIDTH)
  ) u_tail (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_i     (item_chain[TABLE_DEPTH]),
    .hit_i      (hit_chain[TABLE_DEPTH]),
    .sym_i      (sym_chain[TABLE_DEPTH]),
    .ready_o    (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== hdl/hpd_checker.sv =====
// Port-level checks for the Huffman prefix decoder, bound to its top level.
// Depends on hpd_pkg and huffman_prefix_decoder.
module hpd_props (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [hpd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [hpd_pkg::OUT_TUSER_W-1:0] out_tuser
);

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot(out_tuser))
    else $error("A result must be either a symbol or an error.");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (out_tdata == '0))
    else $error("An error result must carry a zero symbol.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("A stalled result changed.");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("Reset must leave the block empty and ready.");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("Input stalled while no result is waiting.");

endmodule

bind huffman_prefix_decoder hpd_props u_hpd_props (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== test/hpd_checker.sv =====
// Result checker for the Huffman prefix decoder: watches both stream channels, keeps its own
// copy of the code table and gathered bits, and compares every decoded item in order.
// Depends on hpd_pkg for field widths and the func codes.
module hpd_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [hpd_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [hpd_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [hpd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [hpd_pkg::OUT_TUSER_W-1:0] out_tuser,
  output int                              fail_count,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH   = hpd_pkg::TABLE_DEPTH_DEF;
  localparam int MAX_LEN = hpd_pkg::MAX_CODE_LEN_DEF;
  localparam int CODE_W  = hpd_pkg::CODE_W;

  logic [hpd_pkg::LEN_W-1:0]       ent_len  [DEPTH];
  logic [CODE_W-1:0]               ent_code [DEPTH];
  logic [hpd_pkg::SYM_FIELD_W-1:0] ent_sym  [DEPTH];
  logic [CODE_W-1:0]               acc_bits;
  int                              acc_count;
  hpd_pkg::result_t                decoded_q[$];

  function automatic logic [CODE_W-1:0] code_mask(input int len);
    if (len >= CODE_W) return '1;
    return (CODE_W'(1) << len) - CODE_W'(1);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] seen);
    $display("MISMATCH at %0t: %s expected %0h got %0h", $realtime, what, want, seen);
    fail_count++;
  endtask

  task automatic store_entry(input logic [hpd_pkg::INDEX_W-1:0] idx,
                             input logic [CODE_W-1:0] code,
                             input logic [hpd_pkg::LEN_W-1:0] len,
                             input logic [hpd_pkg::SYM_FIELD_W-1:0] sym);
    if (idx < DEPTH) begin
      ent_len[idx]  = len;
      ent_code[idx] = code & code_mask(int'(len));
      ent_sym[idx]  = sym;
    end
  endtask

  // The lowest matching index wins; an entry longer than the limit can never match.
  task automatic shift_in_bit(input logic b);
    logic             found;
    hpd_pkg::result_t r;
    found = 1'b0;
    r = '0;
    acc_bits = {acc_bits[CODE_W-2:0], b} & code_mask(MAX_LEN);
    acc_count++;
    for (int i = 0; i < DEPTH; i++) begin
      if (!found && ent_len[i] != '0 && int'(ent_len[i]) == acc_count &&
          ent_code[i] == acc_bits) begin
        r.symbol = ent_sym[i];
        r.symbol_valid = 1'b1;
        found = 1'b1;
      end
    end
    if (!found && acc_count >= MAX_LEN) begin
      r.code_error = 1'b1;
      found = 1'b1;
    end
    if (found) begin
      decoded_q = {decoded_q, r};
      acc_bits = '0;
      acc_count = 0;
    end
  endtask

  always @(posedge clk) begin
    hpd_pkg::result_t want;
    hpd_pkg::result_t seen;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) ent_len[i] = '0;
      acc_bits = '0;
      acc_count = 0;
      fail_count = 0;
      decoded_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        seen.symbol = out_tdata[hpd_pkg::SYM_FIELD_W-1:0];
        seen.symbol_valid = out_tuser[0];
        seen.code_error = out_tuser[1];
        if (decoded_q.size() == 0) begin
          report_mismatch("result with nothing expected, symbol", '0, 32'(seen.symbol));
        end else begin
          want = decoded_q.pop_front();
          if (seen.symbol !== want.symbol)
            report_mismatch("symbol", 32'(want.symbol), 32'(seen.symbol));
          if (seen.symbol_valid !== want.symbol_valid)
            report_mismatch("symbol_valid", 32'(want.symbol_valid), 32'(seen.symbol_valid));
          if (seen.code_error !== want.code_error)
            report_mismatch("code_error", 32'(want.code_error), 32'(seen.code_error));
        end
      end
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          hpd_pkg::FUNC_WRITE: begin
            store_entry(in_tdata[7:0], in_tdata[39:8], in_tdata[45:40], in_tdata[61:46]);
          end
          hpd_pkg::FUNC_DECODE: begin
            shift_in_bit(in_tdata[62]);
          end
          hpd_pkg::FUNC_CLEAR: begin
            acc_bits = '0;
            acc_count = 0;
          end
          default: begin
          end
        endcase
      end
    end
    pending <= decoded_q.size();
  end

endmodule

// ===== test/tb_top.sv =====
// Top of the Huffman prefix decoder testbench: clock, reset, stimulus and verdict.
// Loads random prefix code tables and streams their codewords, mixed with noise items.
// Depends on hpd_pkg, huffman_prefix_decoder and hpd_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_RESERVED = 2'd3;
  localparam int         RANDOM_ITEMS  = 1300;
  localparam int         CODE_W        = hpd_pkg::CODE_W;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [hpd_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic [hpd_pkg::IN_TUSER_W-1:0]  in_tuser = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [hpd_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [hpd_pkg::OUT_TUSER_W-1:0] out_tuser;
  int                              fails;
  int                              pending;

  int                              items_sent = 0;
  int                              burst_left = 0;
  int                              stall_left = 0;
  int                              stall_mode = 0;
  logic [7:0]                      stall_pat = 8'hFF;
  logic [CODE_W-1:0]               words[$];
  int                              word_len[$];
  int                              slot_list[$];
  bit                              slot_used[hpd_pkg::TABLE_DEPTH_DEF];

  always #4 clk = ~clk;

  huffman_prefix_decoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  hpd_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fails),
    .pending    (pending)
  );

  // The receiver switches at random between free flow, random stalls, sparse acceptance and a rotating pattern.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
      stall_pat = 8'($urandom);
    end else begin
      stall_left--;
    end
    stall_pat = {stall_pat[6:0], stall_pat[7]};
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 7) == 0);
      default: out_tready <= stall_pat[0] | (stall_pat == 8'h00);
    endcase
  end

  function automatic logic [CODE_W-1:0] len_mask(input int len);
    if (len >= CODE_W) return '1;
    return (CODE_W'(1) << len) - CODE_W'(1);
  endfunction

  task automatic send_item(input logic [1:0] f, input logic [7:0] idx,
                           input logic [31:0] code, input logic [5:0] len,
                           input logic [15:0] sym, input logic b);
    logic rdy;
    int   gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 20);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= f;
    in_tdata <= {1'b0, b, sym, len, code, idx};
    do begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
    end while (!rdy);
    if (f != FUNC_RESERVED) items_sent++;
  endtask

  task automatic load_entry(input logic [7:0] idx, input logic [31:0] code,
                            input logic [5:0] len, input logic [15:0] sym);
    send_item(hpd_pkg::FUNC_WRITE, idx, code, len, sym, 1'($urandom_range(0, 1)));
  endtask

  task automatic push_bit(input logic b);
    send_item(hpd_pkg::FUNC_DECODE, 8'($urandom), $urandom, 6'($urandom), 16'($urandom), b);
  endtask

  task automatic clear_bits();
    send_item(hpd_pkg::FUNC_CLEAR, 8'($urandom), $urandom, 6'($urandom), 16'($urandom),
              1'($urandom_range(0, 1)));
  endtask

  function automatic int claim_slot();
    int s;
    do s = $urandom_range(0, hpd_pkg::TABLE_DEPTH_DEF - 1); while (slot_used[s]);
    slot_used[s] = 1'b1;
    slot_list = {slot_list, s};
    return s;
  endfunction

  function automatic bit clashes(input logic [CODE_W-1:0] c, input int l);
    int m;
    foreach (words[j]) begin
      m = (l < word_len[j]) ? l : word_len[j];
      if ((c >> (l - m)) == (words[j] >> (word_len[j] - m))) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 6);
    if (r < 18) return $urandom_range(7, 16);
    if (r == 18) return $urandom_range(17, 31);
    return CODE_W;
  endfunction

  task automatic noise_item();
    case ($urandom_range(0, 3))
      0: clear_bits();
      1: send_item(FUNC_RESERVED, 8'($urandom), $urandom, 6'($urandom), 16'($urandom),
                   1'($urandom_range(0, 1)));
      2: push_bit(1'($urandom_range(0, 1)));
      default: load_entry(8'(claim_slot()), $urandom, 6'($urandom_range(0, 63)),
                          16'($urandom));
    endcase
  endtask

  // One table phase: retire the old entries, then push random bits alone, or load a
  // fresh prefix code and stream its codewords, now and then broken by noise items.
  task automatic run_phase();
    int                len;
    int                slot;
    int                tries;
    int                pick;
    bit                ok;
    logic [CODE_W-1:0] bits;
    foreach (slot_list[j]) load_entry(8'(slot_list[j]), $urandom, 6'd0, 16'($urandom));
    foreach (slot_list[j]) slot_used[slot_list[j]] = 1'b0;
    slot_list.delete();
    words.delete();
    word_len.delete();
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(33, 70)) push_bit(1'($urandom_range(0, 1)));
      return;
    end
    repeat ($urandom_range(2, 12)) begin
      ok = 1'b0;
      tries = 0;
      len = 0;
      bits = '0;
      while (!ok && tries < 20) begin
        len = pick_len();
        bits = $urandom & len_mask(len);
        ok = !clashes(bits, len);
        tries++;
      end
      if (ok) begin
        slot = claim_slot();
        words = {words, bits};
        word_len = {word_len, len};
        load_entry(8'(slot), ($urandom & ~len_mask(len)) | bits, 6'(len), 16'($urandom));
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      slot = claim_slot();
      load_entry(8'(slot), words[0], 6'(word_len[0]), 16'($urandom));
    end
    clear_bits();
    repeat ($urandom_range(10, 40)) begin
      if ($urandom_range(0, 29) == 0) noise_item();
      pick = $urandom_range(0, words.size() - 1);
      for (int b = word_len[pick] - 1; b >= 0; b--) push_bit(words[pick][b]);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Two entries share the code 10; the lower slot must win until it is invalidated.
    load_entry(8'd0, 32'hFFFF_FFFE, 6'd2, 16'hFFFF);
    load_entry(8'd7, 32'h0000_0002, 6'd2, 16'h1234);
    load_entry(8'd255, 32'hFFFF_FFFF, 6'd32, 16'h0000);
    load_entry(8'd9, 32'h0000_0000, 6'd63, 16'hABCD);
    load_entry(8'd10, 32'h0000_0000, 6'd33, 16'h5555);
    send_item(FUNC_RESERVED, 8'hFF, 32'hFFFF_FFFF, 6'h3F, 16'hFFFF, 1'b1);
    push_bit(1'b1);
    push_bit(1'b0);
    push_bit(1'b0);
    clear_bits();
    push_bit(1'b1);
    push_bit(1'b0);
    load_entry(8'd0, 32'hFFFF_FFFF, 6'd0, 16'hFFFF);
    push_bit(1'b1);
    push_bit(1'b0);
    load_entry(8'd7, 32'h0000_0000, 6'd0, 16'h0000);
    load_entry(8'd9, 32'h0000_0000, 6'd0, 16'h0000);
    load_entry(8'd10, 32'h0000_0000, 6'd0, 16'h0000);
    load_entry(8'd255, 32'h0000_0000, 6'd0, 16'h0000);
    clear_bits();

    begin
      int target;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) run_phase();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (hpd_pkg::TABLE_DEPTH_DEF + 50) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("huffman_prefix_decoder test passed");
    end else begin
      $display("huffman_prefix_decoder test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("huffman_prefix_decoder test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/hpd_pkg.sv
hdl/hpd_cell.sv
hdl/hpd_tail.sv
hdl/huffman_prefix_decoder.sv
hdl/hpd_checker.sv
test/hpd_checker.sv
test/tb_top.sv
